// ===== rtl/vadpcm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vector ADPCM decoder package
// Request types, opcodes, sizing constants and the small arithmetic helpers
// shared by the decoder.
// ----------------------------------------------------------------------------
package vadpcm_pkg;

    localparam int PREDICTOR_COUNT_DEF = 16;
    localparam int TAPS                = 8;
    localparam int SHIFT_FRAC          = 11;
    localparam int SCALE_CAP           = 12;
    localparam int ACC_W               = 40;
    localparam int FRAME_DATA_BYTES    = 8;

    localparam logic signed [ACC_W-1:0] SAMPLE_MAX = 40'sd32767;
    localparam logic signed [ACC_W-1:0] SAMPLE_MIN = -40'sd32768;

    typedef enum logic [1:0] {
        OP_CB_WRITE   = 2'd0,
        OP_HIST_CLEAR = 2'd1,
        OP_HIST_LOAD  = 2'd2,
        OP_FRAME_BYTE = 2'd3
    } t_opcode;

    typedef struct packed {
        t_opcode            opcode;
        logic        [7:0]  entry_index;
        logic signed [15:0] entry_value;
        logic signed [15:0] history_older;
        logic signed [15:0] history_newer;
        logic        [7:0]  code_byte;
    } t_in_req;

    typedef struct packed {
        logic signed [15:0] first_sample;
        logic signed [15:0] second_sample;
        logic               frame_end;
    } t_out_req;

    // Signed nibble shifted left by the scale, capped at 12, kept to 16 bits.
    function automatic logic signed [15:0] residual(input logic [3:0] nib,
                                                    input logic [3:0] scale);
        logic [15:0] ext;
        logic [3:0]  sh;
        ext = {{12{nib[3]}}, nib};
        sh  = (scale < 4'(SCALE_CAP)) ? scale : 4'(SCALE_CAP);
        return $signed(ext << sh);
    endfunction

    // Arithmetic shift right by 11 and saturation to the 16-bit sample range.
    function automatic logic signed [15:0] saturate(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W-1:0] sh;
        sh = acc >>> SHIFT_FRAC;
        if (sh > SAMPLE_MAX) begin
            return 16'sh7FFF;
        end else if (sh < SAMPLE_MIN) begin
            return 16'sh8000;
        end
        return sh[15:0];
    endfunction

endpackage

// ===== rtl/vector_adpcm_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vector ADPCM decoder
// Order-2 codebook prediction of 4-bit residual frames, one shared MAC.
// ----------------------------------------------------------------------------
// Usage: requests arrive on the input channel (i_in_valid / o_in_stall) and
// carry one of four opcodes: codebook write, history clear, history load or
// frame byte. A frame is a header byte followed by eight data bytes; each data
// byte yields one output request on o_out_valid / i_out_stall with two samples
// and a frame end flag. Other requests produce no output.
// Codebook writes, history requests and header bytes never raise o_in_stall.
// A data byte at group position k (0, 2, 4, 6) occupies the block from its
// accept until its result is loaded into the output register: the first
// sample needs k + 2 products and the second k + 3 through the single 16x16
// multiplier, fed from the registered codebook read port, and each sample
// then passes the pipeline drain states S_WAIT1 and S_WAIT2 and the
// saturation state S_SAT. o_in_stall is high during that work.
// A finished result waits in the output register; when the receiver stalls,
// the block can still take requests that give no output, and a new data byte
// holds its result internally until the output register is free.
// Synchronous active-low reset clears the codebook (through per-entry valid
// bits), history, frame position and header fields; no clearing pass is needed.
// ----------------------------------------------------------------------------
module vector_adpcm_decoder
    import vadpcm_pkg::*;
#(
    parameter int PREDICTOR_COUNT = PREDICTOR_COUNT_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_in_req  i_in_req,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_out_req o_out_req
);

    localparam int CB_DEPTH = PREDICTOR_COUNT * 16;
    localparam int CB_AW    = $clog2(CB_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MAC,
        S_WAIT1,
        S_WAIT2,
        S_SAT,
        S_DONE
    } t_state;

    t_state r_state;

    logic [15:0]        r_cb_mem [CB_DEPTH];
    logic [CB_DEPTH-1:0] r_cb_vld;
    logic [15:0]        r_rd;
    logic               r_rd_ok;

    logic [3:0]         r_pos;
    logic [3:0]         r_scale;
    logic [3:0]         r_pred;
    logic signed [15:0] r_grp [TAPS];
    logic signed [15:0] r_older;
    logic signed [15:0] r_newer;

    logic [2:0]         r_kb;
    logic               r_smp;
    logic [3:0]         r_term;
    logic               r_last;
    logic signed [15:0] r_samp0;
    logic signed [15:0] r_samp1;

    logic               r_s1_vld;
    logic signed [15:0] r_s1_b;
    logic               r_s2_vld;
    logic signed [31:0] r_prod;
    logic signed [ACC_W-1:0] r_acc;

    logic               r_out_vld;
    t_out_req           r_out;

    logic        in_acc;
    logic        cb_we;
    logic [2:0]  kk;
    logic [2:0]  tap_j;
    logic [2:0]  tap;
    logic        half;
    logic [7:0]  rd_addr;
    logic        rd_in_range;
    logic [3:0]  last_term;
    logic [3:0]  pm1;
    logic signed [15:0] res_hi;
    logic signed [15:0] res_lo;
    logic signed [15:0] coef;
    logic signed [15:0] opb;
    logic        out_free;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out_req   = r_out;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign cb_we    = in_acc && (i_in_req.opcode == OP_CB_WRITE)
                      && ({1'b0, i_in_req.entry_index} < 9'(CB_DEPTH));
    assign out_free = !r_out_vld || !i_out_stall;

    // Term 0 is C0[kk]*older, term 1 is C1[kk]*newer, term 2+j is C1[kk-1-j]*r[j].
    assign kk        = {r_kb[2:1], r_smp};
    assign last_term = {1'b0, kk} + 4'd1;
    assign tap_j     = 3'(r_term - 4'd2);
    assign half      = (r_term != 4'd0);
    assign tap       = (r_term < 4'd2) ? kk : 3'(kk - 3'd1 - tap_j);
    assign rd_addr   = {r_pred, half, tap};
    assign rd_in_range = ({1'b0, rd_addr} < 9'(CB_DEPTH));

    always_comb begin
        unique case (r_term)
            4'd0:    opb = r_older;
            4'd1:    opb = r_newer;
            default: opb = r_grp[tap_j];
        endcase
    end

    assign pm1    = r_pos - 4'd1;
    assign res_hi = residual(i_in_req.code_byte[7:4], r_scale);
    assign res_lo = residual(i_in_req.code_byte[3:0], r_scale);
    assign coef   = r_rd_ok ? $signed(r_rd) : 16'sd0;

    // Codebook storage: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (cb_we) begin
            r_cb_mem[i_in_req.entry_index[CB_AW-1:0]] <= i_in_req.entry_value;
        end
        r_rd <= r_cb_mem[rd_addr[CB_AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cb_vld  <= '0;
            r_rd_ok   <= 1'b0;
            r_pos     <= '0;
            r_scale   <= '0;
            r_pred    <= '0;
            r_older   <= '0;
            r_newer   <= '0;
            r_kb      <= '0;
            r_smp     <= 1'b0;
            r_term    <= '0;
            r_last    <= 1'b0;
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_rd_ok  <= rd_in_range && r_cb_vld[rd_addr[CB_AW-1:0]];
            r_s1_vld <= (r_state == S_MAC);
            r_s2_vld <= r_s1_vld;
            r_prod   <= coef * r_s1_b;
            if (r_s2_vld) begin
                r_acc <= r_acc + ACC_W'(r_prod);
            end
            r_out_vld <= (r_state == S_DONE && out_free) || (r_out_vld && i_out_stall);
            if (cb_we) begin
                r_cb_vld[i_in_req.entry_index[CB_AW-1:0]] <= 1'b1;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        unique case (i_in_req.opcode)
                            OP_CB_WRITE: begin
                            end
                            OP_HIST_CLEAR: begin
                                r_older <= '0;
                                r_newer <= '0;
                            end
                            OP_HIST_LOAD: begin
                                r_older <= i_in_req.history_older;
                                r_newer <= i_in_req.history_newer;
                            end
                            OP_FRAME_BYTE: begin
                                if (r_pos == 4'd0 || r_pos > 4'(FRAME_DATA_BYTES)) begin
                                    r_scale <= i_in_req.code_byte[7:4];
                                    r_pred  <= i_in_req.code_byte[3:0];
                                    r_pos   <= 4'd1;
                                end else begin
                                    r_grp[{pm1[1:0], 1'b0}] <= res_hi;
                                    r_grp[{pm1[1:0], 1'b1}] <= res_lo;
                                    r_kb    <= {pm1[1:0], 1'b0};
                                    r_smp   <= 1'b0;
                                    r_term  <= '0;
                                    r_acc   <= ACC_W'(res_hi) <<< SHIFT_FRAC;
                                    r_last  <= (r_pos == 4'(FRAME_DATA_BYTES));
                                    r_pos   <= (r_pos == 4'(FRAME_DATA_BYTES)) ?
                                               4'd0 : r_pos + 4'd1;
                                    r_state <= S_MAC;
                                end
                            end
                        endcase
                    end
                end
                S_MAC: begin
                    r_s1_b   <= opb;
                    r_term   <= r_term + 4'd1;
                    if (r_term == last_term) begin
                        r_state <= S_WAIT1;
                    end
                end
                S_WAIT1: r_state <= S_WAIT2;
                S_WAIT2: r_state <= S_SAT;
                S_SAT: begin
                    if (!r_smp) begin
                        r_samp0 <= saturate(r_acc);
                        r_smp   <= 1'b1;
                        r_term  <= '0;
                        r_acc   <= ACC_W'(r_grp[{r_kb[2:1], 1'b1}]) <<< SHIFT_FRAC;
                        r_state <= S_MAC;
                    end else begin
                        r_samp1 <= saturate(r_acc);
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out.first_sample  <= r_samp0;
                        r_out.second_sample <= r_samp1;
                        r_out.frame_end     <= r_last;
                        // The last group of a half-frame feeds the next prediction.
                        if (r_kb == 3'd6) begin
                            r_older <= r_samp0;
                            r_newer <= r_samp1;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_idle_pipe_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (!r_s1_vld && !r_s2_vld))
        else $error("MAC pipeline busy while accepting requests");

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_DONE))
        else $error("Output request raised outside the completion state");

    a_term_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MAC) |-> (r_term <= last_term))
        else $error("Product term counter overran the sample");

    a_done_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && !out_free) |=> (r_state == S_DONE))
        else $error("Result left the completion state while output was held");
`endif

endmodule

// ===== dv/vector_adpcm_decoder_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vector ADPCM decoder checker
// Watches both request channels of the decoder. It keeps its own copy of the
// codebook, frame position, header fields and history, predicts the sample
// pair for every accepted data byte, and compares each output request field
// by field with the oldest prediction.
// ----------------------------------------------------------------------------
module vector_adpcm_decoder_chk
    import vadpcm_pkg::*;
#(
    parameter int PREDICTOR_COUNT = PREDICTOR_COUNT_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_in_stall,
    input  t_in_req  i_in_req,
    input  logic     i_out_valid,
    input  logic     i_out_stall,
    input  t_out_req i_out_req,
    output int       o_fail_count,
    output int       o_pending,
    output int       o_pair_count
);

    logic signed [15:0] coef_rom [256];
    logic signed [15:0] group_resid [TAPS];
    logic        [3:0]  frame_pos;
    logic        [3:0]  scale_q;
    logic        [3:0]  pred_q;
    logic signed [15:0] hist_older;
    logic signed [15:0] hist_newer;

    t_out_req pairs_due [$];
    int       fail_total = 0;
    int       pair_total = 0;

    assign o_fail_count = fail_total;
    assign o_pending    = pairs_due.size();
    assign o_pair_count = pair_total;

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        fail_total++;
    endtask

    // A predictor beyond the populated range reads as all-zero coefficients.
    function automatic longint tap_coef(input int half, input int tap);
        if (pred_q >= PREDICTOR_COUNT) begin
            return 0;
        end
        return longint'(coef_rom[int'(pred_q) * 16 + half * TAPS + tap]);
    endfunction

    function automatic logic signed [15:0] scale_residual(input logic [3:0] nib);
        longint n;
        int     sh;
        n  = longint'($signed(nib));
        sh = (scale_q < SCALE_CAP) ? int'(scale_q) : SCALE_CAP;
        return 16'(n <<< sh);
    endfunction

    function automatic logic signed [15:0] predict_sample(input int k);
        longint acc;
        int     j;
        acc = tap_coef(0, k) * longint'(hist_older) + tap_coef(1, k) * longint'(hist_newer);
        for (j = 0; j < k; j++) begin
            acc += tap_coef(1, k - 1 - j) * longint'(group_resid[j]);
        end
        acc += longint'(group_resid[k]) * 2048;
        acc = acc >>> SHIFT_FRAC;
        if (acc > SAMPLE_MAX) begin
            return 16'sh7FFF;
        end else if (acc < SAMPLE_MIN) begin
            return 16'sh8000;
        end
        return 16'(acc);
    endfunction

    // Applies one request to the shadow state; returns 1 when it yields a pair.
    function automatic bit decode_request(input t_in_req r, output t_out_req pair);
        int   k;
        logic last;
        pair = '0;
        case (r.opcode)
            OP_CB_WRITE: begin
                if (r.entry_index < PREDICTOR_COUNT * 16) begin
                    coef_rom[r.entry_index] = r.entry_value;
                end
                return 1'b0;
            end
            OP_HIST_CLEAR: begin
                hist_older = '0;
                hist_newer = '0;
                return 1'b0;
            end
            OP_HIST_LOAD: begin
                hist_older = r.history_older;
                hist_newer = r.history_newer;
                return 1'b0;
            end
            OP_FRAME_BYTE: begin
                if (frame_pos == 0 || frame_pos > FRAME_DATA_BYTES) begin
                    scale_q   = r.code_byte[7:4];
                    pred_q    = r.code_byte[3:0];
                    frame_pos = 4'd1;
                    return 1'b0;
                end
                k = 2 * ((int'(frame_pos) - 1) & 3);
                group_resid[k]     = scale_residual(r.code_byte[7:4]);
                group_resid[k + 1] = scale_residual(r.code_byte[3:0]);
                pair.first_sample  = predict_sample(k);
                pair.second_sample = predict_sample(k + 1);
                // The last two samples of a group become the history.
                if (k == TAPS - 2) begin
                    hist_older = pair.first_sample;
                    hist_newer = pair.second_sample;
                end
                last           = (frame_pos == FRAME_DATA_BYTES);
                pair.frame_end = last;
                frame_pos      = last ? 4'd0 : frame_pos + 4'd1;
                return 1'b1;
            end
        endcase
        return 1'b0;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_out_req want;
        t_out_req pair;
        if (!i_rst_n) begin
            foreach (coef_rom[i]) begin
                coef_rom[i] = '0;
            end
            foreach (group_resid[i]) begin
                group_resid[i] = '0;
            end
            frame_pos  = '0;
            scale_q    = '0;
            pred_q     = '0;
            hist_older = '0;
            hist_newer = '0;
            pairs_due.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                pair_total++;
                if (pairs_due.size() == 0) begin
                    report_mismatch($sformatf("unexpected sample pair %0d/%0d end %0b",
                        i_out_req.first_sample, i_out_req.second_sample,
                        i_out_req.frame_end));
                end else begin
                    want = pairs_due.pop_front();
                    if (i_out_req.first_sample !== want.first_sample) begin
                        report_mismatch($sformatf("pair %0d first_sample %0d, expected %0d",
                            pair_total, i_out_req.first_sample, want.first_sample));
                    end
                    if (i_out_req.second_sample !== want.second_sample) begin
                        report_mismatch($sformatf("pair %0d second_sample %0d, expected %0d",
                            pair_total, i_out_req.second_sample, want.second_sample));
                    end
                    if (i_out_req.frame_end !== want.frame_end) begin
                        report_mismatch($sformatf("pair %0d frame_end %0b, expected %0b",
                            pair_total, i_out_req.frame_end, want.frame_end));
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                if (decode_request(i_in_req, pair)) begin
                    pairs_due.push_back(pair);
                end
            end
        end
    end

endmodule

// ===== dv/vector_adpcm_decoder_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vector ADPCM decoder testbench
// Drives codebook writes, history requests and frame bytes into the decoder:
// a directed opening on extreme coefficients, history, scales and nibbles,
// then random frames with interleaved side requests, over four mixes of
// sender idling and receiver stalling. A separate checker predicts and
// compares every sample pair.
// ----------------------------------------------------------------------------
module vector_adpcm_decoder_tb
    import vadpcm_pkg::*;
();

    localparam int ITEM_TARGET  = 1700;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 100;

    logic     clk;
    logic     rst_n;
    logic     in_valid;
    logic     in_stall;
    t_in_req  in_req;
    logic     out_valid;
    logic     out_stall;
    t_out_req out_req;

    int fail_count;
    int pending;
    int pair_count;
    int idle_pct      = 0;
    int stall_pct     = 0;
    int cycle_count   = 0;
    int requests_sent = 0;
    int bytes_sent    = 0;

    vector_adpcm_decoder DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_req    (in_req),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_req   (out_req)
    );

    vector_adpcm_decoder_chk u_chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_req     (in_req),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_req    (out_req),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_pair_count (pair_count)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(negedge clk) begin
        out_stall <= rst_n && ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Every field is random so that unused fields still toggle all their bits.
    function automatic t_in_req random_req(input t_opcode op);
        t_in_req r;
        r.opcode        = op;
        r.entry_index   = 8'($urandom);
        r.entry_value   = 16'($urandom);
        r.history_older = 16'($urandom);
        r.history_newer = 16'($urandom);
        r.code_byte     = 8'($urandom);
        return r;
    endfunction

    // Mostly moderate coefficients, so that not every sample saturates.
    function automatic logic [15:0] random_coef();
        if ($urandom_range(3) == 0) begin
            return 16'($urandom);
        end
        return 16'($urandom_range(4095)) - 16'd2048;
    endfunction

    task automatic send_req(input t_in_req r);
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_req   <= r;
        @(posedge clk);
        while (in_stall) begin
            @(posedge clk);
        end
        requests_sent++;
        @(negedge clk);
    endtask

    task automatic write_coef(input logic [7:0] idx, input logic [15:0] val);
        t_in_req r;
        r = random_req(OP_CB_WRITE);
        r.entry_index = idx;
        r.entry_value = val;
        send_req(r);
    endtask

    task automatic load_history(input logic [15:0] older, input logic [15:0] newer);
        t_in_req r;
        r = random_req(OP_HIST_LOAD);
        r.history_older = older;
        r.history_newer = newer;
        send_req(r);
    endtask

    task automatic send_byte(input logic [7:0] b);
        t_in_req r;
        r = random_req(OP_FRAME_BYTE);
        r.code_byte = b;
        send_req(r);
        bytes_sent++;
    endtask

    task automatic send_side_request();
        send_req(random_req(t_opcode'($urandom_range(int'(OP_HIST_LOAD)))));
    endtask

    // A header for a random predictor, sometimes preceded by fresh coefficients
    // or history; one frame in twenty is cut short to upset the framing.
    task automatic send_random_frame();
        logic [3:0] pred;
        int         data_count;
        pred = 4'($urandom_range(15));
        if ($urandom_range(9) < 3) begin
            repeat ($urandom_range(1, 6)) begin
                write_coef({pred, 4'($urandom_range(15))}, random_coef());
            end
        end
        if ($urandom_range(9) < 2) begin
            load_history(16'($urandom), 16'($urandom));
        end
        send_byte({4'($urandom_range(15)), pred});
        data_count = ($urandom_range(19) == 0) ? $urandom_range(7) : FRAME_DATA_BYTES;
        repeat (data_count) begin
            if ($urandom_range(99) < 8) begin
                send_side_request();
            end
            send_byte(8'($urandom));
        end
    endtask

    task automatic pause_until_drained();
        in_valid <= 1'b0;
        while (pending != 0) begin
            @(negedge clk);
        end
        @(negedge clk);
    endtask

    initial begin
        int phase;
        int phase_end;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_req    = '0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Extreme coefficients and history drive the first samples into saturation.
        write_coef(8'd240, 16'h8000);
        write_coef(8'd248, 16'h7FFF);
        write_coef(8'd255, 16'h7FFF);
        write_coef(8'd0, 16'h7FFF);
        load_history(16'h8000, 16'h7FFF);
        send_byte(8'hFF);
        send_byte(8'h7F);
        send_byte(8'h80);
        load_history(16'h7FFF, 16'h8000);
        send_byte(8'h88);
        send_byte(8'h77);
        send_side_request();
        send_req(random_req(OP_HIST_CLEAR));
        send_byte(8'h00);
        send_byte(8'hFF);
        write_coef(8'd249, 16'h8000);
        send_byte(8'h08);
        send_byte(8'h80);
        // Scale exactly at the cap, predictor zero.
        send_byte(8'hC0);
        repeat (FRAME_DATA_BYTES) begin
            send_byte(8'($urandom));
        end

        for (phase = 0; phase < 4; phase++) begin
            pause_until_drained();
            case (phase)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 87; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 87; end
                default: begin idle_pct = 7; stall_pct = 7; end
            endcase
            phase_end = ITEM_TARGET * (phase + 1) / 4;
            while (requests_sent < phase_end) begin
                send_random_frame();
            end
        end

        in_valid <= 1'b0;
        while (pending != 0) begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Run covered %0d requests, %0d of them frame bytes, and %0d checked pairs,",
            requests_sent, bytes_sent, pair_count);
        $display("under free-running, sender-idle, receiver-stall and mixed traffic.");
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
